// ----- design/direct_dft_macros.svh -----
// assertion macros for the direct dft checker
// expects clk and rst in the scope where a macro is used
`ifndef DIRECT_DFT_MACROS_SVH
`define DIRECT_DFT_MACROS_SVH

// same-cycle implication, held off during reset
`define DDFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define DDFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ddft_pkg.sv -----
// shared types and constants for the direct dft block
// no dependencies
package ddft_pkg;

  localparam int POINTS_DEF = 64;
  localparam int SAMPLE_W   = 16;
  localparam int TW_W       = 16;
  localparam int PROD_W     = SAMPLE_W + TW_W;
  localparam int ACC_W      = 38;
  localparam int OUT_W      = 22;
  localparam int BIN_W      = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_WAIT,
    ST_EMIT
  } dft_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ----- design/ddft_rom.sv -----
// twiddle table: cos and sin of 2*pi*m/POINTS in q1.15, registered read
// built at elaboration from a fixed-point taylor series; uses ddft_pkg
module ddft_rom #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                 clk,
  input  logic [$clog2(POINTS)-1:0]            addr,
  output logic signed [ddft_pkg::TW_W-1:0]     cos_val,
  output logic signed [ddft_pkg::TW_W-1:0]     sin_val
);
  import ddft_pkg::*;

  localparam int TAYLOR_TERMS = 10;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] COS_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
  localparam logic [63:0] SIN_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // clamp q2.30 to [0, 1], round to q1.15
  function automatic logic [TW_W-1:0] to_q15(input logic signed [63:0] v);
    logic [63:0] u;
    if (v < 0) begin
      u = 64'd0;
    end else if (v > signed'(Q30_ONE)) begin
      u = Q30_ONE;
    end else begin
      u = 64'(v);
    end
    u = (u + 64'd16384) >> 15;
    if (u > 64'd32767) begin
      u = 64'd32767;
    end
    return TW_W'(u);
  endfunction

  function automatic logic [POINTS-1:0][2*TW_W-1:0] build_rom();
    logic [POINTS-1:0][2*TW_W-1:0] tab;
    logic [63:0] q, r, a, x2, tc, ts;
    logic signed [63:0] vc, vs;
    logic [TW_W-1:0] c, s, cv, sv;
    for (int m = 0; m < POINTS; m++) begin
      q  = 64'(4 * m) / POINTS;
      r  = 64'(4 * m) - q * 64'(POINTS);
      a  = (HALF_PI_Q30 * r) / POINTS;
      x2 = (a * a) >> 30;
      tc = Q30_ONE;
      ts = a;
      vc = signed'(tc);
      vs = signed'(ts);
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
        tc = ((tc * x2) >> 30) / COS_DIV[i];
        ts = ((ts * x2) >> 30) / SIN_DIV[i];
        if (i[0] == 1'b0) begin
          vc = vc - signed'(tc);
          vs = vs - signed'(ts);
        end else begin
          vc = vc + signed'(tc);
          vs = vs + signed'(ts);
        end
      end
      c = to_q15(vc);
      s = to_q15(vs);
      case (q[1:0])
        2'd0:    begin cv = c;        sv = s;        end
        2'd1:    begin cv = TW_W'(-s); sv = c;        end
        2'd2:    begin cv = TW_W'(-c); sv = TW_W'(-s); end
        default: begin cv = s;        sv = TW_W'(-c); end
      endcase
      tab[m] = {cv, sv};
    end
    return tab;
  endfunction

  localparam logic [POINTS-1:0][2*TW_W-1:0] TWIDDLE = build_rom();

  always_ff @(posedge clk) begin
    {cos_val, sin_val} <= TWIDDLE[addr];
  end

endmodule

// ----- design/ddft_mac.sv -----
// shared multiply-accumulate unit for both bin sums, plus round and saturate
// two-stage: product register, then accumulator; uses ddft_pkg
module ddft_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ddft_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0]  smp,
  input  logic signed [ddft_pkg::TW_W-1:0]      cos_val,
  input  logic signed [ddft_pkg::TW_W-1:0]      sin_val,
  output logic                                  done,
  output logic signed [ddft_pkg::OUT_W-1:0]     real_sat,
  output logic signed [ddft_pkg::OUT_W-1:0]     imag_sat
);
  import ddft_pkg::*;

  localparam int SH_W = ACC_W - 15;

  mac_ctrl_t                 pctrl;
  logic signed [PROD_W-1:0]  prod_re;
  logic signed [PROD_W-1:0]  prod_im;
  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;

  // round half up from q.30 to q.15, then clip to the output range
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [SH_W-1:0]  v;
    t = acc + ACC_W'(16384);
    v = SH_W'(t >>> 15);
    if (v > SH_W'(2097151)) begin
      return OUT_W'(2097151);
    end else if (v < -SH_W'(2097152)) begin
      return OUT_W'(-2097152);
    end
    return OUT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pctrl <= '0;
      done  <= 1'b0;
    end else begin
      pctrl <= ctrl;
      done  <= pctrl.valid && pctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= PROD_W'(smp) * PROD_W'(cos_val);
    prod_im <= PROD_W'(smp) * PROD_W'(sin_val);
    if (pctrl.valid) begin
      if (pctrl.first) begin
        acc_re <= ACC_W'(prod_re);
        acc_im <= -ACC_W'(prod_im);
      end else begin
        acc_re <= acc_re + ACC_W'(prod_re);
        acc_im <= acc_im - ACC_W'(prod_im);
      end
    end
  end

  assign real_sat = round_sat(acc_re);
  assign imag_sat = round_sat(acc_im);

endmodule

// ----- design/direct_dft.sv -----
// direct dft top level: sample store, sequencer, twiddle rom and shared mac
// depends on ddft_pkg, ddft_rom, ddft_mac
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  sample  | sample_valid/sample_ready | sample (signed q1.15)
//  bin     | bin_valid/bin_ready     | bin_index, real_part, imag_part, last_bin
//
// a sample is taken each cycle while loading; the last sample of a frame starts
// the transform. each bin needs POINTS products on the one mac (one cos and one sin
// product per cycle), then the mac pipeline drains and the bin is handed over.
// sync reset clears the sequencer and counters; the sample store is not cleared.
// a stalled bin output holds the sequencer in its emit step; samples are taken
// again as soon as the last bin sits in the output register.
module direct_dft #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  bin_valid,
  input  logic                                  bin_ready,
  output logic [ddft_pkg::BIN_W-1:0]            bin_index,
  output logic signed [ddft_pkg::OUT_W-1:0]     real_part,
  output logic signed [ddft_pkg::OUT_W-1:0]     imag_part,
  output logic                                  last_bin
);
  import ddft_pkg::*;

  localparam int IDX_W = $clog2(POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  dft_state_t state, state_next;

  logic [IDX_W-1:0] load_count;
  logic [IDX_W-1:0] n;     // sample index within the current bin
  logic [IDX_W-1:0] m;     // twiddle index, (k*n) mod POINTS
  logic [IDX_W-1:0] k;     // bin being computed
  logic [IDX_W:0]   m_sum;
  logic [IDX_W-1:0] m_step;

  logic load_last, n_last, k_last, out_free;
  logic store_wr, emit;

  mac_ctrl_t issue, issue_q;

  logic signed [SAMPLE_W-1:0] store [POINTS];
  logic signed [SAMPLE_W-1:0] smp_q;
  logic signed [TW_W-1:0]     cos_val, sin_val;

  logic                       mac_done;
  logic signed [OUT_W-1:0]    real_sat, imag_sat;

  assign load_last = (load_count == LAST_IDX);
  assign n_last    = (n == LAST_IDX);
  assign k_last    = (k == LAST_IDX);
  assign out_free  = !bin_valid || bin_ready;

  // next twiddle index: add k, wrap once
  assign m_sum  = {1'b0, m} + {1'b0, k};
  assign m_step = (m_sum >= (IDX_W+1)'(POINTS)) ? IDX_W'(m_sum - (IDX_W+1)'(POINTS))
                                                : IDX_W'(m_sum);

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (sample_valid && load_last) state_next = ST_CALC;
      ST_CALC: if (n_last) state_next = ST_WAIT;
      ST_WAIT: if (mac_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = k_last ? ST_LOAD : ST_CALC;
      default: state_next = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample_ready = 1'b0;
    emit         = 1'b0;
    issue        = '0;
    case (state)
      ST_LOAD: sample_ready = 1'b1;
      ST_CALC: begin
        issue.valid = 1'b1;
        issue.first = (n == '0);
        issue.last  = n_last;
      end
      ST_WAIT: emit = 1'b0;
      ST_EMIT: emit = out_free;
      default: sample_ready = 1'b0;
    endcase
  end

  assign store_wr = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      n          <= '0;
      m          <= '0;
      k          <= '0;
      issue_q    <= '0;
    end else begin
      state   <= state_next;
      issue_q <= issue;
      if (store_wr) begin
        load_count <= load_last ? '0 : load_count + 1'b1;
      end
      // n and m sweep one bin, then rest at zero for the next one
      if (state == ST_CALC) begin
        n <= n_last ? '0 : n + 1'b1;
        m <= n_last ? '0 : m_step;
      end
      if (emit) begin
        k <= k_last ? '0 : k + 1'b1;
      end
    end
  end

  // sample store, registered read lines up with the twiddle rom
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[load_count] <= sample;
    end
    smp_q <= store[n];
  end

  ddft_rom #(.POINTS(POINTS)) u_rom (
    .clk     (clk),
    .addr    (m),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  ddft_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (issue_q),
    .smp      (smp_q),
    .cos_val  (cos_val),
    .sin_val  (sin_val),
    .done     (mac_done),
    .real_sat (real_sat),
    .imag_sat (imag_sat)
  );

  // output register, parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else if (emit) begin
      bin_valid <= 1'b1;
    end else if (bin_ready) begin
      bin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bin_index <= BIN_W'(k);
      real_part <= real_sat;
      imag_part <= imag_sat;
      last_bin  <= k_last;
    end
  end

endmodule

// ----- design/ddft_checker.sv -----
// port-level checks for direct_dft, bound to every instance
// depends on ddft_pkg and direct_dft_macros.svh
`include "direct_dft_macros.svh"

module ddft_props #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  sample_valid,
  input logic                                  sample_ready,
  input logic                                  bin_valid,
  input logic                                  bin_ready,
  input logic [ddft_pkg::BIN_W-1:0]            bin_index,
  input logic signed [ddft_pkg::OUT_W-1:0]     real_part,
  input logic signed [ddft_pkg::OUT_W-1:0]     imag_part,
  input logic                                  last_bin
);
  import ddft_pkg::*;

  localparam logic [BIN_W-1:0] LAST_BIN_IDX = BIN_W'(POINTS - 1);

  // a stalled bin keeps its contents
  `DDFT_ASSERT_NEXT(a_bin_hold, bin_valid && !bin_ready, bin_valid && $stable(bin_index) && $stable(real_part) && $stable(imag_part) && $stable(last_bin), "bin changed while stalled")

  // the frame flag only rides on the top bin
  `DDFT_ASSERT_NOW(a_last_index, bin_valid && last_bin, bin_index == LAST_BIN_IDX, "last flag on wrong bin")

  // no sample is taken while the frame still has bins to deliver
  `DDFT_ASSERT_NOW(a_no_load_mid_frame, bin_valid && !last_bin, !sample_ready, "sample ready during frame output")

  // loading stops only on an accepted sample
  `DDFT_ASSERT_NOW(a_ready_drop, $fell(sample_ready), $past(sample_valid), "ready fell without a sample")

endmodule

bind direct_dft ddft_props #(.POINTS(POINTS)) u_checker (.*);

// ----- tb/ddft_checker.sv -----
`timescale 1ns / 100ps
// frame-level predictor and result compare for the direct dft block
// depends on ddft_pkg for port widths; watches both channels of direct_dft
module ddft_checker #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  input  logic                                  sample_ready,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  bin_valid,
  input  logic                                  bin_ready,
  input  logic [ddft_pkg::BIN_W-1:0]            bin_index,
  input  logic signed [ddft_pkg::OUT_W-1:0]     real_part,
  input  logic signed [ddft_pkg::OUT_W-1:0]     imag_part,
  input  logic                                  last_bin,
  output int                                    mismatch_count,
  output int                                    pending_bins
);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint          BIN_MAX = 2097151;
  localparam longint          BIN_MIN = -2097152;

  typedef struct {
    logic [ddft_pkg::BIN_W-1:0]        k;
    logic signed [ddft_pkg::OUT_W-1:0] re;
    logic signed [ddft_pkg::OUT_W-1:0] im;
    logic                              last;
  } dft_bin_t;

  dft_bin_t                          expected_bins[$];
  logic signed [ddft_pkg::SAMPLE_W-1:0] frame_samples[POINTS];
  int                                frame_fill = 0;
  int                                cos_rom[POINTS];
  int                                sin_rom[POINTS];
  int                                fails = 0;
  int                                pending = 0;

  assign mismatch_count = fails;
  assign pending_bins   = pending;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // q2.30 magnitude to q1.15, clamped to [0, 32767]
  function automatic int to_q15(input longint v);
    longint u;
    if (v < 0) v = 0;
    if (v > longint'(Q30_ONE)) v = longint'(Q30_ONE);
    u = (v + 16384) >>> 15;
    if (u > 32767) u = 32767;
    return int'(u);
  endfunction

  // taylor series for cos and sin of a first-quadrant angle
  function automatic void quarter_wave(input longint unsigned ang, output int c, output int s);
    longint unsigned sq, tc, ts, dc, ds;
    longint vc, vs;
    sq = (ang * ang) >> 30;
    tc = Q30_ONE;
    ts = ang;
    vc = longint'(tc);
    vs = longint'(ts);
    for (int i = 1; i <= 10; i++) begin
      dc = longint'((2 * i - 1) * (2 * i));
      ds = longint'((2 * i) * (2 * i + 1));
      tc = ((tc * sq) >> 30) / dc;
      ts = ((ts * sq) >> 30) / ds;
      if (i % 2 == 1) begin
        vc -= longint'(tc);
        vs -= longint'(ts);
      end else begin
        vc += longint'(tc);
        vs += longint'(ts);
      end
    end
    c = to_q15(vc);
    s = to_q15(vs);
  endfunction

  function automatic logic signed [ddft_pkg::OUT_W-1:0] round_to_bin(input longint acc);
    longint v;
    v = (acc + 16384) >>> 15;
    if (v > BIN_MAX) v = BIN_MAX;
    if (v < BIN_MIN) v = BIN_MIN;
    return v[ddft_pkg::OUT_W-1:0];
  endfunction

  // twiddle rom built once from quadrant and remainder
  initial begin
    int q, r, c, s;
    longint unsigned ang;
    for (int m = 0; m < POINTS; m++) begin
      q   = (4 * m) / POINTS;
      r   = 4 * m - q * POINTS;
      ang = (HALF_PI * longint'(r)) / longint'(POINTS);
      quarter_wave(ang, c, s);
      case (q % 4)
        0:       begin cos_rom[m] = c;  sin_rom[m] = s;  end
        1:       begin cos_rom[m] = -s; sin_rom[m] = c;  end
        2:       begin cos_rom[m] = -c; sin_rom[m] = -s; end
        default: begin cos_rom[m] = s;  sin_rom[m] = -c; end
      endcase
    end
  end

  task automatic transform_frame();
    dft_bin_t b;
    longint   re, im;
    int       m;
    for (int k = 0; k < POINTS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < POINTS; n++) begin
        m  = (k * n) % POINTS;
        re += longint'(frame_samples[n]) * cos_rom[m];
        im -= longint'(frame_samples[n]) * sin_rom[m];
      end
      b.k    = k[ddft_pkg::BIN_W-1:0];
      b.re   = round_to_bin(re);
      b.im   = round_to_bin(im);
      b.last = (k == POINTS - 1);
      expected_bins.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    dft_bin_t want;
    if (rst) begin
      expected_bins.delete();
      frame_fill = 0;
    end else begin
      if (bin_valid && bin_ready) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("bin with nothing expected, bin_index", bin_index, -1);
        end else begin
          want = expected_bins.pop_front();
          if (bin_index !== want.k)  report_mismatch("bin_index", bin_index, want.k);
          if (real_part !== want.re) report_mismatch("real_part", real_part, want.re);
          if (imag_part !== want.im) report_mismatch("imag_part", imag_part, want.im);
          if (last_bin !== want.last) report_mismatch("last_bin", last_bin, want.last);
        end
      end
      if (sample_valid && sample_ready) begin
        frame_samples[frame_fill] = sample;
        frame_fill++;
        if (frame_fill == POINTS) begin
          transform_frame();
          frame_fill = 0;
        end
      end
    end
    pending = expected_bins.size();
  end

endmodule

// ----- tb/direct_dft_test.sv -----
`timescale 1ns / 100ps
// top of the direct dft testbench: clock, reset, sample stimulus, bin back-pressure
// depends on ddft_pkg, direct_dft and ddft_checker
module direct_dft_test;

  localparam int POINTS       = ddft_pkg::POINTS_DEF;
  localparam int CORNER_ITEMS = 25;
  // two whole frames plus a partial one that must produce nothing
  localparam int TOTAL_ITEMS  = 2 * POINTS + 22;
  // a bin passes POINTS products through the shared mac, plus stalls; allow far more
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 2 * (POINTS + 5);

  // content shapes for the frames after the corner items
  typedef enum int {
    PAT_FULL,
    PAT_MAX,
    PAT_MIN,
    PAT_ALT,
    PAT_SMALL,
    PAT_IMPULSE
  } frame_pat_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  sample_valid;
  logic                                  sample_ready;
  logic signed [ddft_pkg::SAMPLE_W-1:0]  sample;
  logic                                  bin_valid;
  logic                                  bin_ready;
  logic [ddft_pkg::BIN_W-1:0]            bin_index;
  logic signed [ddft_pkg::OUT_W-1:0]     real_part;
  logic signed [ddft_pkg::OUT_W-1:0]     imag_part;
  logic                                  last_bin;
  int                                    mismatch_count;
  int                                    pending_bins;
  int                                    quiet_cycles;
  // when set, neither side inserts idle cycles
  logic                                  no_gaps;

  // corner samples that open the first frame: extremes, sign boundary, bit patterns
  logic signed [ddft_pkg::SAMPLE_W-1:0] corner_samples[CORNER_ITEMS] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
    16'sh5555, 16'shaaaa, 16'sh4000, 16'shc000, 16'sh7fff,
    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0f0f, 16'shf0f0,
    16'sh00ff, 16'shff00, 16'sh7ffe, 16'sh8001, 16'sh3333,
    16'shcccc, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0000
  };

  direct_dft #(
    .POINTS(POINTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .bin_valid    (bin_valid),
    .bin_ready    (bin_ready),
    .bin_index    (bin_index),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .last_bin     (last_bin)
  );

  ddft_checker #(
    .POINTS(POINTS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .bin_valid      (bin_valid),
    .bin_ready      (bin_ready),
    .bin_index      (bin_index),
    .real_part      (real_part),
    .imag_part      (imag_part),
    .last_bin       (last_bin),
    .mismatch_count (mismatch_count),
    .pending_bins   (pending_bins)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: ends the run if no item moves on either channel for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_valid && sample_ready) || (bin_valid && bin_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles, %0d bins outstanding",
               $realtime, STALL_LIMIT, pending_bins);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one sample; entered and left at a falling edge
  task automatic push_sample(input logic signed [ddft_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1'b1;
    sample       = value;
    // valid holds with a steady payload until the rising edge that takes it
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // bin side: a fresh random stall before each bin is taken, none when no_gaps is set
  initial begin
    int stall;
    bin_ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        bin_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      bin_ready = 1'b1;
      do @(posedge clk); while (!(bin_valid && bin_ready));
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    frame_pat_t                           pat;
    int                                   pos;
    int                                   spike_pos;
    logic signed [ddft_pkg::SAMPLE_W-1:0] value;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    no_gaps      = 1'b0;
    pat          = PAT_FULL;
    spike_pos    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < TOTAL_ITEMS; i++) begin
      pos = i % POINTS;
      if (pos == 0 && i > 0) begin
        // pressure: the third frame waits until every bin so far has come out
        if (i == 2 * POINTS) begin
          sample_valid = 1'b0;
          while (pending_bins != 0) @(negedge clk);
        end
        pat       = frame_pat_t'($urandom_range(0, 5));
        spike_pos = $urandom_range(0, POINTS - 1);
        // roughly one frame in three runs back to back on both sides
        no_gaps   = ($urandom_range(0, 2) == 0);
      end
      if (i < CORNER_ITEMS) begin
        value = corner_samples[i];
      end else begin
        case (pat)
          PAT_MAX:     value = 16'sh7fff;
          PAT_MIN:     value = 16'sh8000;
          PAT_ALT:     value = pos[0] ? 16'sh8000 : 16'sh7fff;
          PAT_SMALL:   value = 16'($signed($urandom_range(0, 511)) - 256);
          PAT_IMPULSE: value = 16'((pos == spike_pos) ? $urandom_range(0, 65535) : 0);
          default:     value = 16'($urandom_range(0, 65535));
        endcase
      end
      push_sample(value);
    end
    sample_valid = 1'b0;
    no_gaps      = 1'b0;

    // drain whatever bins are still owed, then give the block time to misbehave
    while (pending_bins != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_bins == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ddft_pkg.sv
design/ddft_rom.sv
design/ddft_mac.sv
design/direct_dft.sv
design/ddft_checker.sv
tb/ddft_checker.sv
tb/direct_dft_test.sv
